/* rtl/nad_pkg.sv */
// shared types, constants and helpers of the netlink attribute deframer
// no dependencies; used by every module under rtl/ except nad_fifo
package nad_pkg;

  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 1;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int OUT_DEPTH_DEF   = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_ORDER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ARRAY_MODE = 1'd1;

  // byte classes
  localparam logic [2:0] CLS_ALIGN    = 3'd0;
  localparam logic [2:0] CLS_LEN_HDR  = 3'd1;
  localparam logic [2:0] CLS_TYPE_HDR = 3'd2;
  localparam logic [2:0] CLS_PAYLOAD  = 3'd3;
  localparam logic [2:0] CLS_PAD      = 3'd4;
  localparam logic [2:0] CLS_UNPARSED = 3'd5;
  localparam logic [2:0] CLS_ELEM_HDR = 3'd6;
  localparam logic [2:0] CLS_ERROR    = 3'd7;

  localparam logic [15:0] HDR_BYTES = 16'd4;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        region_start;
    logic [15:0] region_length;
    logic [1:0]  start_align;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  byte_class;
    logic [7:0]  byte_out;
    logic [13:0] attr_kind;
    logic        nested_flag;
    logic        net_order_flag;
    logic [15:0] payload_length;
    logic [15:0] element_index;
    logic        in_element;
    logic        bounds_error;
    logic        region_last;
  } out_item_t;

  // word after the front end has decoded the region-start fields
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        region_start;
    logic [15:0] region_length;
    logic [1:0]  skip;
    logic        zero_len;
    logic        short_region;
  } dec_item_t;

  typedef struct packed {
    logic       byte_order;
    logic       array_mode;
  } cfg_regs_t;

  function automatic logic [15:0] join16(input logic big, input logic [7:0] first,
                                         input logic [7:0] second);
    join16 = big ? {first, second} : {second, first};
  endfunction

  // padding after a clipped length c, rounded up to 4 and clipped to dl
  function automatic logic [2:0] clip_pad(input logic [16:0] c, input logic [16:0] dl);
    logic [17:0] t;
    logic [17:0] d;
    t = ({1'b0, c} + 18'd3) & ~18'd3;
    d = (t < {1'b0, dl}) ? (t - {1'b0, c}) : ({1'b0, dl} - {1'b0, c});
    clip_pad = d[2:0];
  endfunction

endpackage

/* rtl/netlink_attribute_deframer.sv */
// Netlink attribute deframer: takes one byte word per cycle and returns one classified result
// word per byte, in order. A pushed word is written into the input queue, taken combinationally
// by the parser, written into the result queue when that has room, and popped from there; the
// parser is combinational, so one word a cycle is sustained as long as pop keeps up. A queue of
// QUEUE_DEPTH words sits between the decode front end and the parser, and a result queue of
// OUT_DEPTH words holds finished words, so either side may stall on its own.
// Configuration writes are always ready and take effect on the next byte the parser takes.
// depends on nad_pkg, nad_front, nad_fifo, nad_back
module netlink_attribute_deframer #(
  parameter int QUEUE_DEPTH = nad_pkg::QUEUE_DEPTH_DEF,
  parameter int OUT_DEPTH   = nad_pkg::OUT_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  nad_pkg::in_item_t              in_item,
  output logic                           empty,
  input  logic                           pop,
  output nad_pkg::out_item_t             out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [nad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nad_pkg::CFG_DATA_W-1:0] cfg_data
);
  import nad_pkg::*;

  dec_item_t dec_item;
  dec_item_t mid_item;
  out_item_t result;
  logic      mid_empty;
  logic      item_take;
  logic      res_full;
  logic      res_push;

  nad_front u_front (
    .in_item  (in_item),
    .dec_item (dec_item)
  );

  nad_fifo #(
    .WIDTH ($bits(dec_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (dec_item),
    .full    (full),
    .rd_en   (item_take),
    .rd_data (mid_item),
    .empty   (mid_empty)
  );

  nad_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (!mid_empty),
    .item       (mid_item),
    .item_take  (item_take),
    .res_full   (res_full),
    .res_push   (res_push),
    .result     (result)
  );

  nad_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (result),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (out_item),
    .empty   (empty)
  );

endmodule

/* rtl/nad_fifo.sv */
// small first-in first-out queue of words
// depends on nothing; used by netlink_attribute_deframer
module nad_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* rtl/nad_front.sv */
// front end: decodes region-start fields of each incoming byte word
// depends on nad_pkg
module nad_front (
  input  nad_pkg::in_item_t  in_item,
  output nad_pkg::dec_item_t dec_item
);
  import nad_pkg::*;

  logic [1:0] skip;

  // bytes to the next 4-byte boundary
  assign skip = 2'd0 - in_item.start_align;

  always_comb begin
    dec_item.data_byte     = in_item.data_byte;
    dec_item.region_start  = in_item.region_start;
    dec_item.region_length = in_item.region_length;
    dec_item.skip          = skip;
    dec_item.zero_len      = (in_item.region_length == 16'd0);
    dec_item.short_region  = (in_item.region_length < {14'd0, skip});
  end

endmodule

/* rtl/nad_back.sv */
// back end: byte-level attribute parser and configuration registers
// depends on nad_pkg
module nad_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [nad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nad_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic               item_valid,
  input  nad_pkg::dec_item_t item,
  output logic               item_take,
  input  logic               res_full,
  output logic               res_push,
  output nad_pkg::out_item_t result
);
  import nad_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_ALIGN, PH_ERROR, PH_UNPARSED,
    PH_LEN0, PH_LEN1, PH_TYPE0, PH_TYPE1, PH_PAY, PH_PAD,
    PH_ELEN0, PH_ELEN1, PH_EIDX0, PH_EIDX1, PH_EUNP, PH_EPAD
  } phase_t;

  function automatic phase_t enter_outer(input logic [15:0] orem, input logic am);
    if (orem == 16'd0) begin
      enter_outer = PH_IDLE;
    end else if (orem >= HDR_BYTES) begin
      enter_outer = am ? PH_ELEN0 : PH_LEN0;
    end else begin
      enter_outer = PH_UNPARSED;
    end
  endfunction

  function automatic phase_t elem_finish(input logic [2:0] epad, input logic [15:0] orem,
                                         input logic am);
    elem_finish = (epad != 3'd0) ? PH_EPAD : enter_outer(orem, am);
  endfunction

  function automatic phase_t enter_inner(input logic [15:0] irem, input logic [2:0] epad,
                                         input logic [15:0] orem, input logic am);
    if (irem >= HDR_BYTES) begin
      enter_inner = PH_LEN0;
    end else if (irem != 16'd0) begin
      enter_inner = PH_EUNP;
    end else begin
      enter_inner = elem_finish(epad, orem, am);
    end
  endfunction

  cfg_regs_t   cfg_r, cfg_nxt;
  phase_t      phase_r, phase_nxt;
  logic [15:0] outer_rem_r, outer_rem_nxt;
  logic [15:0] inner_rem_r, inner_rem_nxt;
  logic [15:0] byte_cnt_r, byte_cnt_nxt;
  logic [15:0] attr_len_r, attr_len_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [2:0]  apad_r, apad_nxt;
  logic [2:0]  epad_r, epad_nxt;
  logic [15:0] cur_attr_r, cur_attr_nxt;
  logic [15:0] cur_idx_r, cur_idx_nxt;

  phase_t      ph;
  logic        am;
  logic        last, attr_ph, inner_level, in_elem;
  logic [15:0] span, len;
  logic [16:0] dl, clip;

  assign cfg_ready = 1'b1;
  assign item_take = item_valid && !res_full;
  assign res_push  = item_take;
  assign am        = cfg_r.array_mode;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_BYTE_ORDER: cfg_nxt.byte_order = cfg_data[0];
        CFG_ARRAY_MODE: cfg_nxt.array_mode = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    outer_rem_nxt = outer_rem_r;
    inner_rem_nxt = inner_rem_r;
    byte_cnt_nxt  = byte_cnt_r;
    attr_len_nxt  = attr_len_r;
    hold_nxt      = hold_r;
    apad_nxt      = apad_r;
    epad_nxt      = epad_r;
    cur_attr_nxt  = cur_attr_r;
    cur_idx_nxt   = cur_idx_r;
    ph            = PH_IDLE;
    last          = 1'b0;
    attr_ph       = 1'b0;
    inner_level   = 1'b0;
    in_elem       = 1'b0;
    span          = 16'd0;
    len           = 16'd0;
    dl            = 17'd0;
    clip          = 17'd0;

    result                = '0;
    result.byte_class     = CLS_UNPARSED;
    result.byte_out       = item.data_byte;

    if (item.region_start) begin
      inner_rem_nxt = 16'd0;
      byte_cnt_nxt  = 16'd0;
      attr_len_nxt  = 16'd0;
      hold_nxt      = 8'd0;
      apad_nxt      = 3'd0;
      epad_nxt      = 3'd0;
      cur_attr_nxt  = 16'd0;
      cur_idx_nxt   = 16'd0;
      outer_rem_nxt = item.region_length;
      if (item.zero_len) begin
        phase_nxt = PH_IDLE;
      end else if (item.short_region) begin
        phase_nxt = PH_ERROR;
      end else if (item.skip != 2'd0) begin
        phase_nxt    = PH_ALIGN;
        byte_cnt_nxt = {14'd0, item.skip};
      end else begin
        phase_nxt = enter_outer(item.region_length, am);
      end
    end

    if (item.region_start && item.zero_len) begin
      // empty region: only the start byte is reported
      result.byte_class   = (item.skip != 2'd0) ? CLS_ERROR : CLS_UNPARSED;
      result.bounds_error = (item.skip != 2'd0);
      result.region_last  = 1'b1;
    end else if (phase_nxt != PH_IDLE) begin
      ph = phase_nxt;
      if (outer_rem_nxt != 16'd0) begin
        outer_rem_nxt = outer_rem_nxt - 16'd1;
      end
      last        = (outer_rem_nxt == 16'd0);
      attr_ph     = (ph >= PH_LEN0) && (ph <= PH_PAD);
      inner_level = am && attr_ph;
      in_elem     = am && (attr_ph || ph >= PH_ELEN0);
      if (inner_level && inner_rem_nxt != 16'd0) begin
        inner_rem_nxt = inner_rem_nxt - 16'd1;
      end
      span = inner_level ? inner_rem_nxt : outer_rem_nxt;

      case (ph)
        PH_ALIGN: begin
          result.byte_class = CLS_ALIGN;
          if (byte_cnt_nxt != 16'd0) begin
            byte_cnt_nxt = byte_cnt_nxt - 16'd1;
          end
          if (byte_cnt_nxt == 16'd0) begin
            phase_nxt = enter_outer(outer_rem_nxt, am);
          end
        end
        PH_ERROR: begin
          result.byte_class = CLS_ERROR;
        end
        PH_UNPARSED: begin
          result.byte_class = CLS_UNPARSED;
        end
        PH_LEN0: begin
          result.byte_class = CLS_LEN_HDR;
          hold_nxt     = item.data_byte;
          cur_attr_nxt = 16'd0;
          attr_len_nxt = 16'd0;
          phase_nxt    = PH_LEN1;
        end
        PH_LEN1: begin
          result.byte_class = CLS_LEN_HDR;
          len  = join16(cfg_r.byte_order, hold_nxt, item.data_byte);
          dl   = {1'b0, span} + 17'd2;
          clip = ({1'b0, len} < dl) ? {1'b0, len} : dl;
          if (len < HDR_BYTES || clip < 17'd4) begin
            // bad length stops this level
            if (!am) begin
              phase_nxt = PH_UNPARSED;
            end else if (inner_rem_nxt != 16'd0) begin
              phase_nxt = PH_EUNP;
            end else begin
              phase_nxt = elem_finish(epad_nxt, outer_rem_nxt, am);
            end
          end else begin
            attr_len_nxt = clip[15:0];
            apad_nxt     = clip_pad(clip, dl);
            byte_cnt_nxt = clip[15:0] - HDR_BYTES;
            phase_nxt    = PH_TYPE0;
          end
        end
        PH_TYPE0: begin
          result.byte_class = CLS_TYPE_HDR;
          hold_nxt  = item.data_byte;
          phase_nxt = PH_TYPE1;
        end
        PH_TYPE1, PH_PAY: begin
          if (ph == PH_TYPE1) begin
            result.byte_class = CLS_TYPE_HDR;
            cur_attr_nxt = join16(cfg_r.byte_order, hold_nxt, item.data_byte);
          end else begin
            result.byte_class = CLS_PAYLOAD;
            if (byte_cnt_nxt != 16'd0) begin
              byte_cnt_nxt = byte_cnt_nxt - 16'd1;
            end
          end
          if (byte_cnt_nxt != 16'd0) begin
            phase_nxt = PH_PAY;
          end else if (apad_nxt != 3'd0) begin
            byte_cnt_nxt = {13'd0, apad_nxt};
            phase_nxt    = PH_PAD;
          end else if (am) begin
            phase_nxt = enter_inner(inner_rem_nxt, epad_nxt, outer_rem_nxt, am);
          end else begin
            phase_nxt = enter_outer(outer_rem_nxt, am);
          end
        end
        PH_PAD: begin
          result.byte_class = CLS_PAD;
          if (byte_cnt_nxt != 16'd0) begin
            byte_cnt_nxt = byte_cnt_nxt - 16'd1;
          end
          if (byte_cnt_nxt == 16'd0) begin
            if (am) begin
              phase_nxt = enter_inner(inner_rem_nxt, epad_nxt, outer_rem_nxt, am);
            end else begin
              phase_nxt = enter_outer(outer_rem_nxt, am);
            end
          end
        end
        PH_ELEN0: begin
          result.byte_class = CLS_ELEM_HDR;
          hold_nxt      = item.data_byte;
          cur_idx_nxt   = 16'd0;
          inner_rem_nxt = 16'd0;
          epad_nxt      = 3'd0;
          phase_nxt     = PH_ELEN1;
        end
        PH_ELEN1: begin
          result.byte_class = CLS_ELEM_HDR;
          len  = join16(cfg_r.byte_order, hold_nxt, item.data_byte);
          dl   = {1'b0, outer_rem_nxt} + 17'd2;
          clip = ({1'b0, len} < dl) ? {1'b0, len} : dl;
          if (len < HDR_BYTES || clip < 17'd4) begin
            phase_nxt = PH_UNPARSED;
          end else begin
            epad_nxt      = clip_pad(clip, dl);
            inner_rem_nxt = clip[15:0] - HDR_BYTES;
            phase_nxt     = PH_EIDX0;
          end
        end
        PH_EIDX0: begin
          result.byte_class = CLS_ELEM_HDR;
          hold_nxt  = item.data_byte;
          phase_nxt = PH_EIDX1;
        end
        PH_EIDX1: begin
          result.byte_class = CLS_ELEM_HDR;
          cur_idx_nxt = join16(cfg_r.byte_order, hold_nxt, item.data_byte);
          phase_nxt   = enter_inner(inner_rem_nxt, epad_nxt, outer_rem_nxt, am);
        end
        PH_EUNP: begin
          result.byte_class = CLS_UNPARSED;
          if (inner_rem_nxt != 16'd0) begin
            inner_rem_nxt = inner_rem_nxt - 16'd1;
          end
          if (inner_rem_nxt == 16'd0) begin
            phase_nxt = elem_finish(epad_nxt, outer_rem_nxt, am);
          end
        end
        PH_EPAD: begin
          result.byte_class = CLS_PAD;
          if (epad_nxt != 3'd0) begin
            epad_nxt = epad_nxt - 3'd1;
          end
          if (epad_nxt == 3'd0) begin
            phase_nxt = enter_outer(outer_rem_nxt, am);
          end
        end
        default: begin
          result.byte_class = CLS_UNPARSED;
        end
      endcase

      if (last) begin
        phase_nxt = PH_IDLE;
      end

      if (attr_ph) begin
        result.attr_kind      = cur_attr_nxt[13:0];
        result.nested_flag    = cur_attr_nxt[15];
        result.net_order_flag = cur_attr_nxt[14];
        result.payload_length = (attr_len_nxt >= HDR_BYTES) ? attr_len_nxt - HDR_BYTES : 16'd0;
      end
      if (in_elem) begin
        result.element_index = cur_idx_nxt;
        result.in_element    = 1'b1;
      end
      result.bounds_error = (ph == PH_ERROR);
      result.region_last  = last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '0;
      phase_r     <= PH_IDLE;
      outer_rem_r <= '0;
      inner_rem_r <= '0;
      byte_cnt_r  <= '0;
      attr_len_r  <= '0;
      hold_r      <= '0;
      apad_r      <= '0;
      epad_r      <= '0;
      cur_attr_r  <= '0;
      cur_idx_r   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
      if (item_take) begin
        phase_r     <= phase_nxt;
        outer_rem_r <= outer_rem_nxt;
        inner_rem_r <= inner_rem_nxt;
        byte_cnt_r  <= byte_cnt_nxt;
        attr_len_r  <= attr_len_nxt;
        hold_r      <= hold_nxt;
        apad_r      <= apad_nxt;
        epad_r      <= epad_nxt;
        cur_attr_r  <= cur_attr_nxt;
        cur_idx_r   <= cur_idx_nxt;
      end
    end
  end

endmodule

/* tb/sv/netlink_attribute_deframer_test.sv */
// self-checking testbench for netlink_attribute_deframer: byte streams of attribute regions,
// a scoreboard class predicts each classified word and compares it with what pops out
// depends on nad_pkg and the deframer rtl
`timescale 1ns / 1ps

module netlink_attribute_deframer_test;
  import nad_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef enum bit [3:0] {
    ST_IDLE, ST_ALIGN, ST_ERROR, ST_REST,
    ST_LEN0, ST_LEN1, ST_TYPE0, ST_TYPE1, ST_PAYLOAD, ST_APAD,
    ST_ELEN0, ST_ELEN1, ST_EIDX0, ST_EIDX1, ST_EREST, ST_EPAD
  } stage_t;

  class deframe_scoreboard;
    bit          byte_order, array_mode;
    int unsigned outer_left, inner_left, count, attr_len, attr_pad, elem_pad;
    logic [7:0]  first_byte;
    logic [15:0] attr_type, elem_index;
    stage_t      stage;
    out_item_t   due_words[$];
    int          errors, words_seen;

    function new();
      stage = ST_IDLE;
      outer_left = 0;
      inner_left = 0;
      count = 0;
      attr_len = 0;
      attr_pad = 0;
      elem_pad = 0;
      first_byte = '0;
      attr_type = '0;
      elem_index = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_BYTE_ORDER) byte_order = val[0];
      else if (idx == CFG_ARRAY_MODE) array_mode = val[0];
    endfunction

    function logic [15:0] pair(logic [7:0] a, logic [7:0] b);
      return byte_order ? {a, b} : {b, a};
    endfunction

    // padding after clipped length c, rounded up to 4 and clipped to the room left
    function int unsigned pad_after(int unsigned c, int unsigned room);
      int unsigned t;
      t = (c + 3) & ~32'd3;
      return (t < room ? t : room) - c;
    endfunction

    function void enter_outer();
      if (outer_left == 0) stage = ST_IDLE;
      else if (outer_left >= 4) stage = array_mode ? ST_ELEN0 : ST_LEN0;
      else stage = ST_REST;
    endfunction

    function void elem_finish();
      if (elem_pad > 0) stage = ST_EPAD;
      else enter_outer();
    endfunction

    function void enter_inner();
      if (inner_left >= 4) stage = ST_LEN0;
      else if (inner_left > 0) stage = ST_EREST;
      else elem_finish();
    endfunction

    function void level_end();
      if (array_mode) enter_inner();
      else enter_outer();
    endfunction

    function out_item_t classify_byte(in_item_t it);
      out_item_t   r;
      int unsigned skip, len, room, c, span;
      bit          last, attr_st, inner_lvl, in_elem;
      stage_t      st;
      r = '0;
      r.byte_class = CLS_UNPARSED;
      r.byte_out = it.data_byte;
      if (it.region_start) begin
        skip = (4 - it.start_align) & 3;
        inner_left = 0;
        count = 0;
        attr_len = 0;
        attr_pad = 0;
        elem_pad = 0;
        first_byte = '0;
        attr_type = '0;
        elem_index = '0;
        if (it.region_length == 0) begin
          stage = ST_IDLE;
          outer_left = 0;
          r.byte_class = (skip != 0) ? CLS_ERROR : CLS_UNPARSED;
          r.bounds_error = (skip != 0);
          r.region_last = 1'b1;
          return r;
        end
        outer_left = it.region_length;
        if (it.region_length < skip) begin
          stage = ST_ERROR;
        end else if (skip > 0) begin
          stage = ST_ALIGN;
          count = skip;
        end else begin
          enter_outer();
        end
      end
      st = stage;
      if (st == ST_IDLE) return r;

      if (outer_left > 0) outer_left--;
      last = (outer_left == 0);
      attr_st = (st >= ST_LEN0 && st <= ST_APAD);
      inner_lvl = array_mode && attr_st;
      in_elem = array_mode && (attr_st || st >= ST_ELEN0);
      if (inner_lvl && inner_left > 0) inner_left--;
      span = inner_lvl ? inner_left : outer_left;

      case (st)
        ST_ALIGN: begin
          r.byte_class = CLS_ALIGN;
          if (count > 0) count--;
          if (count == 0) enter_outer();
        end
        ST_ERROR: r.byte_class = CLS_ERROR;
        ST_REST: r.byte_class = CLS_UNPARSED;
        ST_LEN0: begin
          r.byte_class = CLS_LEN_HDR;
          first_byte = it.data_byte;
          attr_type = '0;
          attr_len = 0;
          stage = ST_LEN1;
        end
        ST_LEN1: begin
          r.byte_class = CLS_LEN_HDR;
          len = pair(first_byte, it.data_byte);
          room = span + 2;
          c = (len < room) ? len : room;
          if (len < 4 || c < 4) begin
            // short length stops this level; inside an element the element pad still follows
            if (!array_mode) stage = ST_REST;
            else if (inner_left > 0) stage = ST_EREST;
            else elem_finish();
          end else begin
            attr_len = c;
            attr_pad = pad_after(c, room);
            count = c - 4;
            stage = ST_TYPE0;
          end
        end
        ST_TYPE0: begin
          r.byte_class = CLS_TYPE_HDR;
          first_byte = it.data_byte;
          stage = ST_TYPE1;
        end
        ST_TYPE1, ST_PAYLOAD: begin
          if (st == ST_TYPE1) begin
            r.byte_class = CLS_TYPE_HDR;
            attr_type = pair(first_byte, it.data_byte);
          end else begin
            r.byte_class = CLS_PAYLOAD;
            if (count > 0) count--;
          end
          if (count > 0) begin
            stage = ST_PAYLOAD;
          end else if (attr_pad > 0) begin
            count = attr_pad;
            stage = ST_APAD;
          end else begin
            level_end();
          end
        end
        ST_APAD: begin
          r.byte_class = CLS_PAD;
          if (count > 0) count--;
          if (count == 0) level_end();
        end
        ST_ELEN0: begin
          r.byte_class = CLS_ELEM_HDR;
          first_byte = it.data_byte;
          elem_index = '0;
          inner_left = 0;
          elem_pad = 0;
          stage = ST_ELEN1;
        end
        ST_ELEN1: begin
          r.byte_class = CLS_ELEM_HDR;
          len = pair(first_byte, it.data_byte);
          room = outer_left + 2;
          c = (len < room) ? len : room;
          if (len < 4 || c < 4) begin
            stage = ST_REST;
          end else begin
            elem_pad = pad_after(c, room);
            inner_left = c - 4;
            stage = ST_EIDX0;
          end
        end
        ST_EIDX0: begin
          r.byte_class = CLS_ELEM_HDR;
          first_byte = it.data_byte;
          stage = ST_EIDX1;
        end
        ST_EIDX1: begin
          r.byte_class = CLS_ELEM_HDR;
          elem_index = pair(first_byte, it.data_byte);
          enter_inner();
        end
        ST_EREST: begin
          r.byte_class = CLS_UNPARSED;
          if (inner_left > 0) inner_left--;
          if (inner_left == 0) elem_finish();
        end
        default: begin
          r.byte_class = CLS_PAD;
          if (elem_pad > 0) elem_pad--;
          if (elem_pad == 0) enter_outer();
        end
      endcase

      if (last) stage = ST_IDLE;
      if (attr_st) begin
        r.attr_kind = attr_type[13:0];
        r.nested_flag = attr_type[15];
        r.net_order_flag = attr_type[14];
        r.payload_length = (attr_len >= 4) ? 16'(attr_len - 4) : 16'd0;
      end
      if (in_elem) begin
        r.element_index = elem_index;
        r.in_element = 1'b1;
      end
      r.bounds_error = (st == ST_ERROR);
      r.region_last = last;
      return r;
    endfunction

    function void note_byte(in_item_t it);
      due_words.push_back(classify_byte(it));
    endfunction

    function int pending();
      return due_words.size();
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void check_word(out_item_t got);
      out_item_t want;
      string     diff;
      words_seen++;
      if (due_words.size() == 0) begin
        flag($sformatf("word %h popped with nothing pending", got));
        return;
      end
      want = due_words.pop_front();
      diff = "";
      if (got.byte_class !== want.byte_class) diff = {diff, " byte_class"};
      if (got.byte_out !== want.byte_out) diff = {diff, " byte_out"};
      if (got.attr_kind !== want.attr_kind) diff = {diff, " attr_kind"};
      if (got.nested_flag !== want.nested_flag) diff = {diff, " nested_flag"};
      if (got.net_order_flag !== want.net_order_flag) diff = {diff, " net_order_flag"};
      if (got.payload_length !== want.payload_length) diff = {diff, " payload_length"};
      if (got.element_index !== want.element_index) diff = {diff, " element_index"};
      if (got.in_element !== want.in_element) diff = {diff, " in_element"};
      if (got.bounds_error !== want.bounds_error) diff = {diff, " bounds_error"};
      if (got.region_last !== want.region_last) diff = {diff, " region_last"};
      if (diff != "")
        flag($sformatf("word %0d mismatch on%s: expected %h got %h", words_seen, diff, want, got));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  in_item_t              in_item = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  deframe_scoreboard sb = new();
  logic [7:0]        region_bytes[$];
  bit                order_now, mode_now, held_off;
  int                idle_pct, stall_pct, bytes_sent, cycle_count;

  netlink_attribute_deframer uut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  task automatic send_word(input in_item_t it);
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_item <= it;
    push <= 1'b1;
    do @(posedge clk); while (full);
    sb.note_byte(it);
    bytes_sent++;
  endtask

  task automatic send_fields(input logic [7:0] d, input logic s, input logic [15:0] len,
                             input logic [1:0] al);
    in_item_t it;
    it.data_byte = d;
    it.region_start = s;
    it.region_length = len;
    it.start_align = al;
    send_word(it);
  endtask

  // sends region_bytes with the start fields on the first word only
  task automatic push_region(input logic [1:0] al, input logic [15:0] len);
    in_item_t it;
    foreach (region_bytes[i]) begin
      it.data_byte = region_bytes[i];
      it.region_start = (i == 0);
      it.region_length = (i == 0) ? len : 16'($urandom());
      it.start_align = (i == 0) ? al : 2'($urandom());
      send_word(it);
    end
  endtask

  function automatic void put16(input logic [15:0] v);
    if (order_now) begin
      region_bytes.push_back(v[15:8]);
      region_bytes.push_back(v[7:0]);
    end else begin
      region_bytes.push_back(v[7:0]);
      region_bytes.push_back(v[15:8]);
    end
  endfunction

  function automatic void add_attr(input bit drop_pad);
    int          plen;
    logic [15:0] lf;
    plen = ($urandom_range(0, 14) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 9);
    lf = 16'(plen + 4);
    case ($urandom_range(0, 15))
      0: lf = 16'($urandom_range(0, 3));
      1: lf = 16'hFFFF;
      2: lf = lf + 16'($urandom_range(1, 6));
      default: ;
    endcase
    put16(lf);
    put16(16'($urandom()));
    repeat (plen) region_bytes.push_back(8'($urandom()));
    if (!drop_pad) repeat ((4 - plen % 4) % 4) region_bytes.push_back(8'($urandom()));
  endfunction

  task automatic send_region();
    logic [1:0]  al;
    int          skip, n, hdr_at, blen, rlen, declared;
    logic [15:0] lf;
    region_bytes.delete();
    al = 2'($urandom());
    skip = (4 - al) & 3;
    repeat (skip) region_bytes.push_back(8'($urandom()));
    n = $urandom_range(1, 4);
    for (int k = 0; k < n; k++) begin
      if (mode_now) begin
        hdr_at = region_bytes.size();
        put16(16'd0);
        put16(16'($urandom()));
        blen = $urandom_range(0, 3);
        for (int j = 0; j < blen; j++) add_attr(j == blen - 1 && $urandom_range(0, 2) == 0);
        lf = 16'(region_bytes.size() - hdr_at);
        repeat ((4 - lf % 4) % 4) region_bytes.push_back(8'($urandom()));
        case ($urandom_range(0, 11))
          0: lf = 16'($urandom_range(0, 3));
          1: lf = 16'hFFFF;
          2: lf = lf + 16'($urandom_range(1, 5));
          default: ;
        endcase
        // element length is known only after the body, so patch it in
        region_bytes[hdr_at] = order_now ? lf[15:8] : lf[7:0];
        region_bytes[hdr_at + 1] = order_now ? lf[7:0] : lf[15:8];
      end else begin
        add_attr(k == n - 1 && $urandom_range(0, 2) == 0);
      end
    end
    rlen = region_bytes.size();
    case ($urandom_range(0, 11))
      0: rlen = $urandom_range(0, rlen);
      1: rlen = rlen + $urandom_range(1, 7);
      default: ;
    endcase
    while (region_bytes.size() > rlen && region_bytes.size() > 1) void'(region_bytes.pop_back());
    while (region_bytes.size() < rlen) region_bytes.push_back(8'($urandom()));
    declared = rlen;
    // now and then the region is left open and the next start abandons it
    if ($urandom_range(0, 15) == 0) declared = rlen + $urandom_range(1, 200);
    push_region(al, 16'(declared));
  endtask

  task automatic send_noise();
    in_item_t it;
    repeat ($urandom_range(1, 6)) begin
      it.data_byte = 8'($urandom());
      it.region_start = ($urandom_range(0, 3) == 0);
      it.region_length = 16'($urandom());
      it.start_align = 2'($urandom());
      send_word(it);
    end
  endtask

  task automatic cfg_set(input bit bo, input bit am);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_BYTE_ORDER;
    cfg_data <= bo;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(CFG_BYTE_ORDER, bo);
    cfg_index <= CFG_ARRAY_MODE;
    cfg_data <= am;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(CFG_ARRAY_MODE, am);
    cfg_valid <= 1'b0;
    order_now = bo;
    mode_now = am;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // result side: random stalls plus one long hold-off so the input backs up
  initial begin
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!held_off && sb.words_seen >= 400) begin
        held_off = 1'b1;
        pop <= 1'b0;
        for (int n = 0; n < 120; n++) @(posedge clk);
      end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      if (!empty) sb.check_word(out_item);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    int target;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (!rst_n);

    // directed: no open region, empty regions, region shorter than its skip
    send_fields(8'hFF, 1'b0, 16'hFFFF, 2'd3);
    send_fields(8'h00, 1'b1, 16'd0, 2'd1);
    send_fields(8'hFF, 1'b1, 16'd0, 2'd0);
    send_fields(8'hA5, 1'b1, 16'd2, 2'd1);
    send_fields(8'h5A, 1'b0, 16'd0, 2'd0);
    // length field below header size, then a new start abandons the long region
    region_bytes = '{8'h03, 8'h00, 8'hFF, 8'h00};
    push_region(2'd0, 16'hFFFF);
    // two skip bytes, one attribute with both flag bits, pad, then a short tail
    region_bytes = '{8'hFF, 8'h00, 8'h06, 8'h00, 8'h01, 8'hC0, 8'hFF, 8'h80,
                     8'h00, 8'h00, 8'h5A, 8'hA5};
    push_region(2'd2, 16'd12);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      if (ph < 4) cfg_set(ph[0], ph[1]);
      else cfg_set($urandom_range(0, 1), $urandom_range(0, 1));
      if (ph == 7) begin
        idle_pct = 0;
        stall_pct = 0;
      end else begin
        idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
      end
      target = bytes_sent + 190;
      while (bytes_sent < target) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        else send_region();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

/* sim.f */
rtl/nad_pkg.sv
rtl/nad_fifo.sv
rtl/nad_front.sv
rtl/nad_back.sv
rtl/netlink_attribute_deframer.sv
tb/sv/netlink_attribute_deframer_test.sv
